// ===== hw/rtl/traffic_light_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Traffic light controller assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlc assertion failed in the same cycle");

// The consequent holds in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlc assertion failed in the next cycle");

`endif

// ===== hw/rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Traffic light controller package
// Types, mode and phase codes, display kinds and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_NIGHT     = 2'd1;
  localparam logic [1:0] MODE_EMERGENCY = 2'd2;

  localparam logic [1:0] PHASE_NS_GREEN  = 2'd0;
  localparam logic [1:0] PHASE_NS_YELLOW = 2'd1;
  localparam logic [1:0] PHASE_EW_GREEN  = 2'd2;
  localparam logic [1:0] PHASE_EW_YELLOW = 2'd3;

  localparam logic [1:0] KIND_COUNT     = 2'd0;
  localparam logic [1:0] KIND_NIGHT     = 2'd1;
  localparam logic [1:0] KIND_EMERGENCY = 2'd2;

  localparam logic [1:0] REG_GREEN_SECONDS   = 2'd0;
  localparam logic [1:0] REG_YELLOW_FLASHES  = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_SEC   = 2'd2;
  localparam logic [1:0] REG_EMER_STEP_TICKS = 2'd3;

  localparam logic [6:0] COUNT_MAX         = 7'd99;
  localparam logic [6:0] RST_GREEN_SECONDS = 7'd30;
  localparam logic [3:0] RST_YELLOW_FLASH  = 4'd3;
  localparam logic [9:0] RST_TICKS_PER_SEC = 10'd100;
  localparam logic [9:0] RST_EMER_STEP     = 10'd90;

  typedef struct packed {
    logic [6:0] green_seconds;
    logic [3:0] yellow_flashes;
    logic [9:0] ticks_per_second;
    logic [9:0] emergency_step_ticks;
  } tlc_cfg_t;

  typedef struct packed {
    logic       ns_green;
    logic       ns_yellow;
    logic       ns_red;
    logic       ew_green;
    logic       ew_yellow;
    logic       ew_red;
    logic [1:0] display_kind;
    logic [6:0] display_value;
    logic [2:0] sweep_position;
  } tlc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlc_cfg.sv =====
// ----------------------------------------------------------------------------
// Traffic light controller configuration registers
// APB-style register file holding the four timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_cfg
  import tlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tlc_cfg_t         cfg
);

  tlc_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_seconds        <= RST_GREEN_SECONDS;
      cfg_r.yellow_flashes       <= RST_YELLOW_FLASH;
      cfg_r.ticks_per_second     <= RST_TICKS_PER_SEC;
      cfg_r.emergency_step_ticks <= RST_EMER_STEP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GREEN_SECONDS:   cfg_r.green_seconds        <= pwdata[6:0];
        REG_YELLOW_FLASHES:  cfg_r.yellow_flashes       <= pwdata[3:0];
        REG_TICKS_PER_SEC:   cfg_r.ticks_per_second     <= pwdata[9:0];
        REG_EMER_STEP_TICKS: cfg_r.emergency_step_ticks <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GREEN_SECONDS:   prdata = {25'd0, cfg_r.green_seconds};
      REG_YELLOW_FLASHES:  prdata = {28'd0, cfg_r.yellow_flashes};
      REG_TICKS_PER_SEC:   prdata = {22'd0, cfg_r.ticks_per_second};
      REG_EMER_STEP_TICKS: prdata = {22'd0, cfg_r.emergency_step_ticks};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlc_core.sv =====
// ----------------------------------------------------------------------------
// Traffic light controller sequencing core
// Holds the mode, phase and timing state and works out the state and the
// lamp and display result for each accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_core
  import tlc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire logic  add_press,
  input  wire logic  decrease_press,
  input  wire logic  night_press,
  input  wire logic  emergency_press,
  input  wire tlc_cfg_t cfg,
  output tlc_result_t result
);

  logic [1:0] mode_r,   mode_nxt;
  logic [1:0] phase_r,  phase_nxt;
  logic [6:0] sec_r,    sec_nxt;
  logic [3:0] flash_r,  flash_nxt;
  logic       lit_r,    lit_nxt;
  logic [9:0] tick_r,   tick_nxt;
  logic [2:0] sweep_r,  sweep_nxt;

  logic [9:0]  per_second;
  logic [9:0]  per_half;
  logic [9:0]  per_emer;
  logic [6:0]  green_start;
  logic [3:0]  flash_start;
  logic [10:0] tick_inc;
  logic [6:0]  sec_adj;
  logic [3:0]  flash_dec;
  logic        sec_done;
  logic        half_done;
  logic        emer_done;

  always_comb begin
    per_second  = (cfg.ticks_per_second == 10'd0) ? 10'd1 : cfg.ticks_per_second;
    per_half    = (cfg.ticks_per_second[9:1] == 9'd0) ? 10'd1
                                                       : {1'b0, cfg.ticks_per_second[9:1]};
    per_emer    = (cfg.emergency_step_ticks == 10'd0) ? 10'd1 : cfg.emergency_step_ticks;
    if (cfg.green_seconds == 7'd0) begin
      green_start = 7'd1;
    end else if (cfg.green_seconds > COUNT_MAX) begin
      green_start = COUNT_MAX;
    end else begin
      green_start = cfg.green_seconds;
    end
    flash_start = (cfg.yellow_flashes == 4'd0) ? 4'd1 : cfg.yellow_flashes;
    tick_inc    = {1'b0, tick_r} + 11'd1;
    sec_done    = tick_inc >= {1'b0, per_second};
    half_done   = tick_inc >= {1'b0, per_half};
    emer_done   = tick_inc >= {1'b0, per_emer};
    if (decrease_press) begin
      sec_adj = (sec_r > 7'd0) ? sec_r - 7'd1 : sec_r;
    end else if (add_press) begin
      sec_adj = (sec_r < COUNT_MAX) ? sec_r + 7'd1 : sec_r;
    end else begin
      sec_adj = sec_r;
    end
    flash_dec = (flash_r > 4'd0) ? flash_r - 4'd1 : flash_r;
  end

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    sec_nxt   = sec_r;
    flash_nxt = flash_r;
    lit_nxt   = lit_r;
    tick_nxt  = tick_r;
    sweep_nxt = sweep_r;
    if (mode_r != MODE_EMERGENCY && emergency_press) begin
      mode_nxt  = MODE_EMERGENCY;
      tick_nxt  = 10'd0;
      sweep_nxt = 3'd0;
    end else if (mode_r == MODE_NORMAL && night_press) begin
      mode_nxt = MODE_NIGHT;
      tick_nxt = 10'd0;
      lit_nxt  = 1'b0;
    end else if (mode_r == MODE_EMERGENCY) begin
      if (emer_done) begin
        tick_nxt  = 10'd0;
        sweep_nxt = sweep_r + 3'd1;
      end else begin
        tick_nxt = tick_inc[9:0];
      end
    end else if (mode_r == MODE_NIGHT) begin
      if (sec_done) begin
        tick_nxt = 10'd0;
        lit_nxt  = ~lit_r;
      end else begin
        tick_nxt = tick_inc[9:0];
      end
    end else if (!phase_r[0]) begin
      sec_nxt = sec_adj;
      if (sec_done) begin
        tick_nxt = 10'd0;
        if (sec_adj <= 7'd1) begin
          phase_nxt = phase_r + 2'd1;
          lit_nxt   = 1'b0;
          sec_nxt   = green_start;
          flash_nxt = flash_start;
        end else begin
          sec_nxt = sec_adj - 7'd1;
        end
      end else begin
        tick_nxt = tick_inc[9:0];
      end
    end else begin
      if (half_done) begin
        tick_nxt = 10'd0;
        if (!lit_r) begin
          lit_nxt = 1'b1;
        end else begin
          lit_nxt   = 1'b0;
          flash_nxt = flash_dec;
          if (flash_dec == 4'd0) begin
            phase_nxt = phase_r + 2'd1;
            sec_nxt   = green_start;
            flash_nxt = flash_start;
          end
        end
      end else begin
        tick_nxt = tick_inc[9:0];
      end
    end
  end

  always_comb begin
    result = '0;
    if (mode_nxt == MODE_EMERGENCY) begin
      result.ns_red         = 1'b1;
      result.ew_red         = 1'b1;
      result.display_kind   = KIND_EMERGENCY;
      result.sweep_position = sweep_nxt;
    end else if (mode_nxt == MODE_NIGHT) begin
      result.ns_yellow    = lit_nxt;
      result.ew_yellow    = lit_nxt;
      result.display_kind = KIND_NIGHT;
    end else begin
      result.display_kind = KIND_COUNT;
      case (phase_nxt)
        PHASE_NS_GREEN: begin
          result.ns_green      = 1'b1;
          result.ew_red        = 1'b1;
          result.display_value = sec_nxt;
        end
        PHASE_NS_YELLOW: begin
          result.ns_yellow     = lit_nxt;
          result.ew_red        = 1'b1;
          result.display_value = {3'd0, flash_nxt};
        end
        PHASE_EW_GREEN: begin
          result.ew_green      = 1'b1;
          result.ns_red        = 1'b1;
          result.display_value = sec_nxt;
        end
        default: begin
          result.ew_yellow     = lit_nxt;
          result.ns_red        = 1'b1;
          result.display_value = {3'd0, flash_nxt};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      phase_r <= PHASE_NS_GREEN;
      sec_r   <= RST_GREEN_SECONDS;
      flash_r <= RST_YELLOW_FLASH;
      lit_r   <= 1'b0;
      tick_r  <= 10'd0;
      sweep_r <= 3'd0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      sec_r   <= sec_nxt;
      flash_r <= flash_nxt;
      lit_r   <= lit_nxt;
      tick_r  <= tick_nxt;
      sweep_r <= sweep_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlc_out.sv =====
// ----------------------------------------------------------------------------
// Traffic light controller result register
// Holds one result word for the output channel and frees it for the next
// word in the cycle it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_out
  import tlc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire tlc_result_t result,
  output logic        can_load,
  output logic        out_valid,
  input  wire logic   out_ready,
  output tlc_result_t out_result
);

  logic        valid_r;
  tlc_result_t data_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/traffic_light_controller.sv =====
// ----------------------------------------------------------------------------
// Traffic light controller
// Two-way traffic light sequencer advanced by one tick word per input,
// giving one lamp and display word per tick.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_ready  add, decrease, night, emergency
//   out_      output     out_valid/out_ready lamps, display kind/value, sweep
//   APB       config     psel/penable/pready four timing registers
//
// Each accepted tick word's result is registered and shown the cycle after.
// A new word is accepted every cycle while the result register is empty or
// being taken; the state registers and the result register set that rate.
// Synchronous reset restores all registers but result data, and NS green.
// A stalled output holds its word and stops input acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_controller
  import tlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_add_press,
  input  wire logic        in_decrease_press,
  input  wire logic        in_night_press,
  input  wire logic        in_emergency_press,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ns_green,
  output logic             out_ns_yellow,
  output logic             out_ns_red,
  output logic             out_ew_green,
  output logic             out_ew_yellow,
  output logic             out_ew_red,
  output logic [1:0]       out_display_kind,
  output logic [6:0]       out_display_value,
  output logic [2:0]       out_sweep_position,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

`include "traffic_light_controller_macros.svh"

  tlc_cfg_t    cfg;
  tlc_result_t result;
  tlc_result_t out_result;
  logic        can_load;
  logic        step;

  assign in_ready = can_load;
  assign step     = in_valid & can_load;

  tlc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .add_press       (in_add_press),
    .decrease_press  (in_decrease_press),
    .night_press     (in_night_press),
    .emergency_press (in_emergency_press),
    .cfg             (cfg),
    .result          (result)
  );

  tlc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_ns_green       = out_result.ns_green;
  assign out_ns_yellow      = out_result.ns_yellow;
  assign out_ns_red         = out_result.ns_red;
  assign out_ew_green       = out_result.ew_green;
  assign out_ew_yellow      = out_result.ew_yellow;
  assign out_ew_red         = out_result.ew_red;
  assign out_display_kind   = out_result.display_kind;
  assign out_display_value  = out_result.display_value;
  assign out_sweep_position = out_result.sweep_position;

  `TLC_ASSERT_NEXT(a_emer_press_shows_sweep, clk, rst_n, step && in_emergency_press, out_valid && out_display_kind == KIND_EMERGENCY)
  `TLC_ASSERT_SAME(a_emer_all_red, clk, rst_n, out_valid && out_display_kind == KIND_EMERGENCY, out_ns_red && out_ew_red && !out_ns_green && !out_ew_green && !out_ns_yellow && !out_ew_yellow)
  `TLC_ASSERT_SAME(a_night_lamps, clk, rst_n, out_valid && out_display_kind == KIND_NIGHT, !out_ns_red && !out_ew_red && !out_ns_green && !out_ew_green && out_ns_yellow == out_ew_yellow)
  `TLC_ASSERT_SAME(a_count_one_red, clk, rst_n, out_valid && out_display_kind == KIND_COUNT, $onehot({out_ns_red, out_ew_red}) && out_display_value <= COUNT_MAX)

endmodule

`default_nettype wire
